// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL controller tlnp_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CHK_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/tlnp_pkg.sv =====
package tlnp_pkg;

  // Pool geometry and field widths.
  localparam int POOL_SIZE = 64;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int LINK_W    = IDX_W + 1;
  localparam int TAG_W     = 8;
  localparam int CNT_W     = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Operation codes.
  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_FREE   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  // Command transaction.
  typedef struct packed {
    logic [1:0]       mode;
    logic             list_present;
    logic [IDX_W-1:0] list_node;
    logic [TAG_W-1:0] item_type;
  } cmd_t;

  // Result transaction.
  typedef struct packed {
    logic             node_valid;
    logic [IDX_W-1:0] result_node;
    logic [CNT_W-1:0] node_count;
    logic [1:0]       status;
  } result_t;

  // One node of the pool as held in the node memory.
  typedef struct packed {
    logic [LINK_W-1:0] next_link;
    logic [IDX_W-1:0]  prev_link;
    logic [TAG_W-1:0]  node_tag;
    logic [CNT_W-1:0]  use_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Access request from the sequencer to the node store.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  // Control states of the sequencer.
  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC_RD,
    S_ALLOC_FRESH,
    S_ALLOC_NODE,
    S_ALLOC_LINK,
    S_ALLOC_NXT,
    S_FREE_NODE,
    S_FREE_PREV,
    S_FREE_RD_NXT,
    S_FREE_NXT
  } state_t;

  // Builds a result; the node reads as zero when no node is given.
  function automatic result_t mk_result(input logic valid, input logic [IDX_W-1:0] node,
                                        input logic [CNT_W-1:0] count,
                                        input logic [1:0] status);
    result_t r;
    r.node_valid  = valid;
    r.result_node = valid ? node : '0;
    r.node_count  = count;
    r.status      = status;
    return r;
  endfunction

endpackage

// ===== sv/tlnp_ram.sv =====
module tlnp_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 37
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tlnp_store.sv =====
module tlnp_store (
  input  logic               clk,
  input  logic               rst,
  input  tlnp_pkg::mem_req_t req,
  output tlnp_pkg::entry_t   rdata
);

  logic [tlnp_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [tlnp_pkg::POOL_SIZE-1:0] written;
  logic                           written_q;
  logic [tlnp_pkg::IDX_W-1:0]     addr_q;
  tlnp_pkg::entry_t               ram_entry;

  tlnp_ram #(
    .ADDR_W (tlnp_pkg::IDX_W),
    .DATA_W (tlnp_pkg::ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_rdata),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data)
  );

  // One flag per node: set on the first write, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.wr_en) begin
      written[req.wr_addr] <= 1'b1;
    end
  end

  // Track the address and flag that go with the data in the read register.
  always_ff @(posedge clk) begin
    if (rst) begin
      written_q <= 1'b0;
    end else if (req.rd_en) begin
      written_q <= written[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      addr_q <= req.rd_addr;
    end
  end

  // A node never written reads as the reset free chain: next is index plus one,
  // count is zero.
  always_comb begin
    ram_entry = tlnp_pkg::entry_t'(ram_rdata);
    rdata     = ram_entry;
    if (!written_q) begin
      rdata.next_link = tlnp_pkg::LINK_W'(addr_q) + tlnp_pkg::LINK_W'(1);
      rdata.use_count = '0;
    end
  end

endmodule

// ===== sv/tlnp_ctrl.sv =====
`include "assert_macros.svh"

module tlnp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tlnp_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done,
  output tlnp_pkg::result_t  result,
  output tlnp_pkg::mem_req_t req,
  input  tlnp_pkg::entry_t   rdata
);

  tlnp_pkg::state_t             state, state_next;
  tlnp_pkg::cmd_t               cmd_q, cmd_q_next;
  logic [tlnp_pkg::IDX_W-1:0]   cur, cur_next;
  logic [tlnp_pkg::IDX_W-1:0]   steps, steps_next;
  logic [tlnp_pkg::LINK_W-1:0]  free_head, free_head_next;
  logic [tlnp_pkg::IDX_W-1:0]   fresh, fresh_next;
  logic [tlnp_pkg::LINK_W-1:0]  lnk_a, lnk_a_next;
  logic [tlnp_pkg::IDX_W-1:0]   lnk_b, lnk_b_next;
  tlnp_pkg::result_t            res, res_next;
  logic                         res_stb, res_stb_next;
  logic [tlnp_pkg::CNT_W-1:0]   cnt_dec;
  logic [tlnp_pkg::CNT_W-1:0]   cnt_inc;
  logic                         walk_last;

  assign busy   = (state != tlnp_pkg::S_IDLE);
  assign done   = res_stb;
  assign result = res;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlnp_pkg::S_IDLE;
      free_head <= '0;
      res_stb   <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      res_stb   <= res_stb_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    cmd_q <= cmd_q_next;
    cur   <= cur_next;
    steps <= steps_next;
    fresh <= fresh_next;
    lnk_a <= lnk_a_next;
    lnk_b <= lnk_b_next;
    res   <= res_next;
  end

  // Count arithmetic on the entry just read.
  assign cnt_dec = rdata.use_count - tlnp_pkg::CNT_W'(1);
  assign cnt_inc = (rdata.use_count == tlnp_pkg::COUNT_MAX) ? tlnp_pkg::COUNT_MAX :
                   rdata.use_count + tlnp_pkg::CNT_W'(1);

  // The walk stops at the end of a chain, back at its start, or after a full pool.
  assign walk_last = rdata.next_link[tlnp_pkg::IDX_W] ||
                     (rdata.next_link[tlnp_pkg::IDX_W-1:0] == cmd_q.list_node) ||
                     (steps == tlnp_pkg::IDX_W'(tlnp_pkg::POOL_SIZE - 1));

  // Sequencer: next state, memory accesses and results.
  always_comb begin
    state_next     = state;
    cmd_q_next     = cmd_q;
    cur_next       = cur;
    steps_next     = steps;
    free_head_next = free_head;
    fresh_next     = fresh;
    lnk_a_next     = lnk_a;
    lnk_b_next     = lnk_b;
    res_next       = res;
    res_stb_next   = 1'b0;
    req            = '0;

    unique case (state)
      tlnp_pkg::S_IDLE: begin
        if (start) begin
          cmd_q_next = cmd;
          if ((cmd.mode != tlnp_pkg::MODE_SEARCH && cmd.mode != tlnp_pkg::MODE_ADD &&
               cmd.mode != tlnp_pkg::MODE_FREE) ||
              (cmd.mode != tlnp_pkg::MODE_ADD && !cmd.list_present)) begin
            res_next     = tlnp_pkg::mk_result(1'b0, '0, '0, tlnp_pkg::ST_BAD_HANDLE);
            res_stb_next = 1'b1;
          end else if (!cmd.list_present) begin
            state_next = tlnp_pkg::S_ALLOC_RD;
          end else if (cmd.mode == tlnp_pkg::MODE_FREE) begin
            req.rd_en   = 1'b1;
            req.rd_addr = cmd.list_node;
            state_next  = tlnp_pkg::S_FREE_NODE;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = cmd.list_node;
            cur_next    = cmd.list_node;
            steps_next  = '0;
            state_next  = tlnp_pkg::S_WALK;
          end
        end
      end

      // One list member per cycle; the entry of cur is in the read register.
      tlnp_pkg::S_WALK: begin
        if (rdata.use_count == '0) begin
          if (steps == '0) begin
            res_next     = tlnp_pkg::mk_result(1'b0, '0, '0, tlnp_pkg::ST_BAD_HANDLE);
            res_stb_next = 1'b1;
            state_next   = tlnp_pkg::S_IDLE;
          end else if (cmd_q.mode == tlnp_pkg::MODE_SEARCH) begin
            res_next     = tlnp_pkg::mk_result(1'b0, '0, '0, tlnp_pkg::ST_NOT_FOUND);
            res_stb_next = 1'b1;
            state_next   = tlnp_pkg::S_IDLE;
          end else begin
            state_next = tlnp_pkg::S_ALLOC_RD;
          end
        end else if (rdata.node_tag == cmd_q.item_type) begin
          if (cmd_q.mode == tlnp_pkg::MODE_SEARCH) begin
            res_next = tlnp_pkg::mk_result(1'b1, cur, rdata.use_count, tlnp_pkg::ST_OK);
          end else begin
            req.wr_en             = 1'b1;
            req.wr_addr           = cur;
            req.wr_data           = rdata;
            req.wr_data.use_count = cnt_inc;
            res_next = tlnp_pkg::mk_result(1'b1, cur, cnt_inc, tlnp_pkg::ST_OK);
          end
          res_stb_next = 1'b1;
          state_next   = tlnp_pkg::S_IDLE;
        end else if (walk_last) begin
          if (cmd_q.mode == tlnp_pkg::MODE_SEARCH) begin
            res_next     = tlnp_pkg::mk_result(1'b0, '0, '0, tlnp_pkg::ST_NOT_FOUND);
            res_stb_next = 1'b1;
            state_next   = tlnp_pkg::S_IDLE;
          end else begin
            state_next = tlnp_pkg::S_ALLOC_RD;
          end
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = rdata.next_link[tlnp_pkg::IDX_W-1:0];
          cur_next    = rdata.next_link[tlnp_pkg::IDX_W-1:0];
          steps_next  = steps + tlnp_pkg::IDX_W'(1);
        end
      end

      // Take the head of the free chain, if there is one.
      tlnp_pkg::S_ALLOC_RD: begin
        if (free_head[tlnp_pkg::IDX_W]) begin
          res_next     = tlnp_pkg::mk_result(1'b0, '0, '0, tlnp_pkg::ST_EMPTY);
          res_stb_next = 1'b1;
          state_next   = tlnp_pkg::S_IDLE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = free_head[tlnp_pkg::IDX_W-1:0];
          fresh_next  = free_head[tlnp_pkg::IDX_W-1:0];
          state_next  = tlnp_pkg::S_ALLOC_FRESH;
        end
      end

      // Pop the fresh node; a new one-node list is finished here.
      tlnp_pkg::S_ALLOC_FRESH: begin
        free_head_next = rdata.next_link;
        if (!cmd_q.list_present) begin
          req.wr_en             = 1'b1;
          req.wr_addr           = fresh;
          req.wr_data.next_link = tlnp_pkg::LINK_W'(fresh);
          req.wr_data.prev_link = fresh;
          req.wr_data.node_tag  = cmd_q.item_type;
          req.wr_data.use_count = tlnp_pkg::CNT_W'(1);
          res_next     = tlnp_pkg::mk_result(1'b1, fresh, tlnp_pkg::CNT_W'(1), tlnp_pkg::ST_OK);
          res_stb_next = 1'b1;
          state_next   = tlnp_pkg::S_IDLE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = cmd_q.list_node;
          state_next  = tlnp_pkg::S_ALLOC_NODE;
        end
      end

      // Point the given member at the fresh node, keeping its old successor.
      tlnp_pkg::S_ALLOC_NODE: begin
        lnk_a_next            = rdata.next_link;
        req.wr_en             = 1'b1;
        req.wr_addr           = cmd_q.list_node;
        req.wr_data           = rdata;
        req.wr_data.next_link = tlnp_pkg::LINK_W'(fresh);
        state_next            = tlnp_pkg::S_ALLOC_LINK;
      end

      // Fill in the fresh node and fetch its successor.
      tlnp_pkg::S_ALLOC_LINK: begin
        req.wr_en             = 1'b1;
        req.wr_addr           = fresh;
        req.wr_data.next_link = lnk_a;
        req.wr_data.prev_link = cmd_q.list_node;
        req.wr_data.node_tag  = cmd_q.item_type;
        req.wr_data.use_count = tlnp_pkg::CNT_W'(1);
        if (lnk_a[tlnp_pkg::IDX_W]) begin
          res_next     = tlnp_pkg::mk_result(1'b1, fresh, tlnp_pkg::CNT_W'(1), tlnp_pkg::ST_OK);
          res_stb_next = 1'b1;
          state_next   = tlnp_pkg::S_IDLE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = lnk_a[tlnp_pkg::IDX_W-1:0];
          state_next  = tlnp_pkg::S_ALLOC_NXT;
        end
      end

      // The successor now points back at the fresh node.
      tlnp_pkg::S_ALLOC_NXT: begin
        req.wr_en             = 1'b1;
        req.wr_addr           = lnk_a[tlnp_pkg::IDX_W-1:0];
        req.wr_data           = rdata;
        req.wr_data.prev_link = fresh;
        res_next     = tlnp_pkg::mk_result(1'b1, fresh, tlnp_pkg::CNT_W'(1), tlnp_pkg::ST_OK);
        res_stb_next = 1'b1;
        state_next   = tlnp_pkg::S_IDLE;
      end

      // Drop one use; on the last one unlink the node and push it as free.
      tlnp_pkg::S_FREE_NODE: begin
        if (rdata.use_count == '0) begin
          res_next     = tlnp_pkg::mk_result(1'b0, '0, '0, tlnp_pkg::ST_BAD_HANDLE);
          res_stb_next = 1'b1;
          state_next   = tlnp_pkg::S_IDLE;
        end else if (cnt_dec != '0) begin
          req.wr_en             = 1'b1;
          req.wr_addr           = cmd_q.list_node;
          req.wr_data           = rdata;
          req.wr_data.use_count = cnt_dec;
          res_next     = tlnp_pkg::mk_result(1'b1, cmd_q.list_node, cnt_dec, tlnp_pkg::ST_OK);
          res_stb_next = 1'b1;
          state_next   = tlnp_pkg::S_IDLE;
        end else begin
          lnk_a_next            = rdata.next_link;
          lnk_b_next            = rdata.prev_link;
          req.wr_en             = 1'b1;
          req.wr_addr           = cmd_q.list_node;
          req.wr_data           = rdata;
          req.wr_data.next_link = free_head;
          req.wr_data.use_count = '0;
          free_head_next        = tlnp_pkg::LINK_W'(cmd_q.list_node);
          if (rdata.prev_link == cmd_q.list_node) begin
            res_next     = tlnp_pkg::mk_result(1'b0, '0, '0, tlnp_pkg::ST_OK);
            res_stb_next = 1'b1;
            state_next   = tlnp_pkg::S_IDLE;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = rdata.prev_link;
            state_next  = tlnp_pkg::S_FREE_PREV;
          end
        end
      end

      // The previous member skips over the freed node.
      tlnp_pkg::S_FREE_PREV: begin
        req.wr_en             = 1'b1;
        req.wr_addr           = lnk_b;
        req.wr_data           = rdata;
        req.wr_data.next_link = lnk_a;
        if (lnk_a[tlnp_pkg::IDX_W]) begin
          res_next     = tlnp_pkg::mk_result(1'b1, lnk_b, '0, tlnp_pkg::ST_OK);
          res_stb_next = 1'b1;
          state_next   = tlnp_pkg::S_IDLE;
        end else begin
          state_next = tlnp_pkg::S_FREE_RD_NXT;
        end
      end

      // The successor may be the member just written, so it is read afterwards.
      tlnp_pkg::S_FREE_RD_NXT: begin
        req.rd_en   = 1'b1;
        req.rd_addr = lnk_a[tlnp_pkg::IDX_W-1:0];
        state_next  = tlnp_pkg::S_FREE_NXT;
      end

      tlnp_pkg::S_FREE_NXT: begin
        req.wr_en             = 1'b1;
        req.wr_addr           = lnk_a[tlnp_pkg::IDX_W-1:0];
        req.wr_data           = rdata;
        req.wr_data.prev_link = lnk_b;
        res_next     = tlnp_pkg::mk_result(1'b1, lnk_b, '0, tlnp_pkg::ST_OK);
        res_stb_next = 1'b1;
        state_next   = tlnp_pkg::S_IDLE;
      end

      default: begin
        state_next = tlnp_pkg::S_IDLE;
      end
    endcase
  end

  // A node is never read in the cycle it is written.
  `CHK_IMPLY(a_no_rw_clash, clk, rst, req.rd_en && req.wr_en, req.rd_addr != req.wr_addr)
  // A result only follows an accepted command or a busy cycle.
  `CHK_IMPLY(a_done_cause, clk, rst, res_stb, $past(state != tlnp_pkg::S_IDLE || start))
  // Pool empty is only reported while the free chain is empty.
  `CHK_IMPLY(a_empty_real, clk, rst, res_stb && res.status == tlnp_pkg::ST_EMPTY,
             free_head[tlnp_pkg::IDX_W])
  // Releasing the last use pushes that node on the free chain.
  `CHK_NEXT(a_free_push, clk, rst,
            state == tlnp_pkg::S_FREE_NODE && rdata.use_count == tlnp_pkg::CNT_W'(1),
            !free_head[tlnp_pkg::IDX_W] && free_head[tlnp_pkg::IDX_W-1:0] == cmd_q.list_node)

endmodule

// ===== sv/typed_list_node_pool_unit.sv =====
// A search walks the list from the given member, one member per cycle; an add does
// that walk, if given a list, and bumps a match's count, else takes a free node and
// links it in; a free drops a use and, on the last one, unlinks the node. A command
// refused on its mode or on a missing list answers in the next cycle. One command at a
// time; a walk visits at most a full pool of members through the single read port.
// The result strobe cannot be stalled; reset is synchronous and frees all nodes at once.
module typed_list_node_pool_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tlnp_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output tlnp_pkg::result_t result
);

  tlnp_pkg::mem_req_t req;
  tlnp_pkg::entry_t   rdata;

  tlnp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result),
    .req    (req),
    .rdata  (rdata)
  );

  tlnp_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

endmodule

// ===== dv/tb_typed_list_node_pool_unit.sv =====
module tb_typed_list_node_pool_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names only the three real operations.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [tlnp_pkg::LINK_W-1:0] LINK_END =
    tlnp_pkg::LINK_W'(tlnp_pkg::POOL_SIZE);
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 145;
  localparam int HOT_ADDS = 15;

  typedef struct {
    tlnp_pkg::cmd_t c;
    int unsigned    gap;
  } pending_cmd_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  tlnp_pkg::cmd_t    cmd = '0;
  logic              busy;
  logic              done;
  tlnp_pkg::result_t result;

  pending_cmd_t      pending_cmds[$];
  tlnp_pkg::result_t expected_results[$];
  int                mismatches = 0;
  int                quiet_cycles = 0;

  // Shadow copy of the node pool, advanced once per accepted transaction.
  logic [tlnp_pkg::LINK_W-1:0] nxt_ptr [tlnp_pkg::POOL_SIZE];
  logic [tlnp_pkg::IDX_W-1:0]  prv_ptr [tlnp_pkg::POOL_SIZE];
  logic [tlnp_pkg::TAG_W-1:0]  tag_of  [tlnp_pkg::POOL_SIZE];
  logic [tlnp_pkg::CNT_W-1:0]  cnt_of  [tlnp_pkg::POOL_SIZE];
  logic [tlnp_pkg::LINK_W-1:0] free_top;

  typed_list_node_pool_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial forever #5 clk = ~clk;

  function automatic void pool_clear();
    for (int i = 0; i < tlnp_pkg::POOL_SIZE; i++) begin
      nxt_ptr[i] = tlnp_pkg::LINK_W'(i + 1);
      prv_ptr[i] = '0;
      tag_of[i]  = '0;
      cnt_of[i]  = '0;
    end
    free_top = '0;
  endfunction

  function automatic bit node_live(logic [tlnp_pkg::LINK_W-1:0] n);
    return n < LINK_END && cnt_of[n[tlnp_pkg::IDX_W-1:0]] != '0;
  endfunction

  // Walks the circular list from one member; gives LINK_END when the type is absent.
  function automatic logic [tlnp_pkg::LINK_W-1:0] find_type(
      logic [tlnp_pkg::IDX_W-1:0] from, logic [tlnp_pkg::TAG_W-1:0] t);
    logic [tlnp_pkg::LINK_W-1:0] cur;
    cur = {1'b0, from};
    for (int k = 0; k < tlnp_pkg::POOL_SIZE; k++) begin
      if (!node_live(cur)) return LINK_END;
      if (tag_of[cur[tlnp_pkg::IDX_W-1:0]] == t) return cur;
      cur = nxt_ptr[cur[tlnp_pkg::IDX_W-1:0]];
      if (cur == {1'b0, from}) return LINK_END;
    end
    return LINK_END;
  endfunction

  // Applies one command to the shadow pool and returns the result it must produce.
  function automatic tlnp_pkg::result_t pool_apply(tlnp_pkg::cmd_t c);
    tlnp_pkg::result_t           r;
    logic [tlnp_pkg::LINK_W-1:0] hit;
    logic [tlnp_pkg::LINK_W-1:0] fresh;
    logic [tlnp_pkg::LINK_W-1:0] nb;
    logic [tlnp_pkg::IDX_W-1:0]  n;
    logic [tlnp_pkg::IDX_W-1:0]  f;
    logic [tlnp_pkg::IDX_W-1:0]  pv;
    r = '0;
    r.status = tlnp_pkg::ST_BAD_HANDLE;
    n = c.list_node;
    case (c.mode)
      tlnp_pkg::MODE_SEARCH: begin
        if (c.list_present && node_live({1'b0, n})) begin
          hit = find_type(n, c.item_type);
          if (hit >= LINK_END) begin
            r.status = tlnp_pkg::ST_NOT_FOUND;
          end else begin
            r.node_valid  = 1'b1;
            r.result_node = hit[tlnp_pkg::IDX_W-1:0];
            r.node_count  = cnt_of[hit[tlnp_pkg::IDX_W-1:0]];
            r.status      = tlnp_pkg::ST_OK;
          end
        end
      end
      tlnp_pkg::MODE_ADD: begin
        if (!c.list_present || node_live({1'b0, n})) begin
          hit = c.list_present ? find_type(n, c.item_type) : LINK_END;
          if (hit < LINK_END) begin
            // An existing node of this type only gains a use, held at the ceiling.
            if (cnt_of[hit[tlnp_pkg::IDX_W-1:0]] != tlnp_pkg::COUNT_MAX)
              cnt_of[hit[tlnp_pkg::IDX_W-1:0]] =
                cnt_of[hit[tlnp_pkg::IDX_W-1:0]] + tlnp_pkg::CNT_W'(1);
            r.node_valid  = 1'b1;
            r.result_node = hit[tlnp_pkg::IDX_W-1:0];
            r.node_count  = cnt_of[hit[tlnp_pkg::IDX_W-1:0]];
            r.status      = tlnp_pkg::ST_OK;
          end else if (free_top >= LINK_END) begin
            r.status = tlnp_pkg::ST_EMPTY;
          end else begin
            fresh    = free_top;
            f        = fresh[tlnp_pkg::IDX_W-1:0];
            free_top = nxt_ptr[f];
            if (c.list_present) begin
              nb         = nxt_ptr[n];
              prv_ptr[f] = n;
              nxt_ptr[f] = nb;
              if (nb < LINK_END) prv_ptr[nb[tlnp_pkg::IDX_W-1:0]] = f;
              nxt_ptr[n] = fresh;
            end else begin
              prv_ptr[f] = f;
              nxt_ptr[f] = fresh;
            end
            tag_of[f]     = c.item_type;
            cnt_of[f]     = tlnp_pkg::CNT_W'(1);
            r.node_valid  = 1'b1;
            r.result_node = f;
            r.node_count  = tlnp_pkg::CNT_W'(1);
            r.status      = tlnp_pkg::ST_OK;
          end
        end
      end
      tlnp_pkg::MODE_FREE: begin
        if (c.list_present && node_live({1'b0, n})) begin
          cnt_of[n] = cnt_of[n] - tlnp_pkg::CNT_W'(1);
          r.status  = tlnp_pkg::ST_OK;
          if (cnt_of[n] != '0) begin
            r.node_valid  = 1'b1;
            r.result_node = n;
            r.node_count  = cnt_of[n];
          end else begin
            // Last use: unlink and push onto the free chain.
            pv         = prv_ptr[n];
            nb         = nxt_ptr[n];
            nxt_ptr[n] = free_top;
            free_top   = {1'b0, n};
            if (pv != n) begin
              nxt_ptr[pv] = nb;
              if (nb < LINK_END) prv_ptr[nb[tlnp_pkg::IDX_W-1:0]] = pv;
              r.node_valid  = 1'b1;
              r.result_node = pv;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Keeps the queue short so that generated commands see a nearly current pool.
  task automatic throttle();
    while (pending_cmds.size() > 1) @(negedge clk);
  endtask

  task automatic send(input logic [1:0] mode, input logic present, input int node,
                      input int tag, input int unsigned gap);
    pending_cmd_t p;
    throttle();
    p.c.mode         = mode;
    p.c.list_present = present;
    p.c.list_node    = tlnp_pkg::IDX_W'(node);
    p.c.item_type    = tlnp_pkg::TAG_W'(tag);
    p.gap            = gap;
    pending_cmds.push_back(p);
  endtask

  task automatic drain_pending();
    while (pending_cmds.size() != 0 || start) @(negedge clk);
  endtask

  function automatic int pick_live();
    int live_q[$];
    for (int i = 0; i < tlnp_pkg::POOL_SIZE; i++)
      if (cnt_of[i] != '0) live_q.push_back(i);
    if (live_q.size() == 0) return -1;
    return live_q[$urandom_range(0, live_q.size() - 1)];
  endfunction

  // Mostly well-formed commands on live nodes, weighted towards filling or draining.
  task automatic random_cmd(input bit filling, input bit no_gaps);
    tlnp_pkg::cmd_t                    c;
    logic [$bits(tlnp_pkg::cmd_t)-1:0] raw;
    int                                roll;
    int                                n;
    int                                m;
    int unsigned                       gap;
    throttle();
    roll = $urandom_range(0, 99);
    gap  = no_gaps ? 0 : $urandom_range(0, 16);
    n    = pick_live();
    m    = pick_live();
    c.list_present = (n >= 0);
    c.list_node    = (n >= 0) ? tlnp_pkg::IDX_W'(n) :
                     tlnp_pkg::IDX_W'($urandom_range(0, tlnp_pkg::POOL_SIZE - 1));
    c.item_type    = ($urandom_range(0, 1) == 1 && m >= 0) ? tag_of[m] :
                     tlnp_pkg::TAG_W'($urandom_range(0, 255));
    if (roll < 5) begin
      raw = $bits(tlnp_pkg::cmd_t)'($urandom);
      c   = raw;
    end else if (roll < (filling ? 70 : 30)) begin
      c.mode = tlnp_pkg::MODE_ADD;
      if ($urandom_range(0, 4) == 0) c.list_present = 1'b0;
    end else if (roll < (filling ? 90 : 45)) begin
      c.mode = tlnp_pkg::MODE_SEARCH;
    end else begin
      c.mode = tlnp_pkg::MODE_FREE;
    end
    send(c.mode, c.list_present, c.list_node, c.item_type, gap);
  endtask

  // Driver: presents the next command once the previous transaction is taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
    end else if (!start || !busy) begin
      if (pending_cmds.size() != 0 && pending_cmds[0].gap == 0) begin
        start <= 1'b1;
        cmd   <= pending_cmds[0].c;
        pending_cmds.delete(0);
      end else begin
        start <= 1'b0;
        if (pending_cmds.size() != 0) pending_cmds[0].gap--;
      end
    end
  end

  // Monitor: checks the result strobe first, then records the command taken.
  always @(posedge clk) begin
    tlnp_pkg::result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result.node_valid !== want.node_valid) begin
            $error("node_valid: expected %0d, got %0d", want.node_valid, result.node_valid);
            mismatches++;
          end
          if (result.result_node !== want.result_node) begin
            $error("result_node: expected %0d, got %0d", want.result_node,
                   result.result_node);
            mismatches++;
          end
          if (result.node_count !== want.node_count) begin
            $error("node_count: expected %0d, got %0d", want.node_count, result.node_count);
            mismatches++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            mismatches++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(pool_apply(cmd));
    end
  end

  // Watchdog: too long without any transaction on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_typed_list_node_pool_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int hot_node;
    bit no_gaps;
    pool_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Bad handles: no list, unused nodes, and the unused operation.
    send(tlnp_pkg::MODE_SEARCH, 1'b0, 0, 8'h00, 0);
    send(tlnp_pkg::MODE_FREE, 1'b0, 0, 8'h00, 2);
    send(tlnp_pkg::MODE_SEARCH, 1'b1, 63, 8'hFF, 0);
    send(tlnp_pkg::MODE_FREE, 1'b1, 5, 8'h00, 1);
    send(tlnp_pkg::MODE_ADD, 1'b1, 0, 8'h12, 0);
    send(MODE_UNUSED, 1'b1, 0, 8'h00, 3);
    // Build a small list, bump a count through a wrapping walk, then search it.
    send(tlnp_pkg::MODE_ADD, 1'b0, 63, 8'hFF, 0);
    send(tlnp_pkg::MODE_ADD, 1'b1, 0, 8'h00, 0);
    send(tlnp_pkg::MODE_ADD, 1'b1, 1, 8'hFF, 4);
    send(tlnp_pkg::MODE_SEARCH, 1'b1, 1, 8'hFF, 0);
    send(tlnp_pkg::MODE_SEARCH, 1'b1, 0, 8'h5A, 0);
    send(tlnp_pkg::MODE_ADD, 1'b1, 0, 8'hA5, 1);
    send(tlnp_pkg::MODE_SEARCH, 1'b1, 1, 8'hA5, 0);
    // Free a node still counted, then its last use, then the rest down to empty.
    send(tlnp_pkg::MODE_FREE, 1'b1, 0, 8'h00, 0);
    send(tlnp_pkg::MODE_FREE, 1'b1, 0, 8'hFF, 0);
    send(tlnp_pkg::MODE_SEARCH, 1'b1, 2, 8'hFF, 2);
    send(tlnp_pkg::MODE_FREE, 1'b1, 1, 8'h00, 0);
    send(tlnp_pkg::MODE_FREE, 1'b1, 2, 8'h00, 0);
    send(tlnp_pkg::MODE_FREE, 1'b1, 2, 8'h00, 0);
    send(tlnp_pkg::MODE_ADD, 1'b0, 0, 8'h00, 0);
    send(tlnp_pkg::MODE_SEARCH, 1'b1, 2, 8'h00, 5);
    send(tlnp_pkg::MODE_FREE, 1'b1, 2, 8'h00, 0);

    // Give one node several uses of the same type back to back.
    drain_pending();
    hot_node = int'(free_top);
    send(tlnp_pkg::MODE_ADD, 1'b0, 0, 8'hC3, 0);
    repeat (HOT_ADDS) send(tlnp_pkg::MODE_ADD, 1'b1, hot_node, 8'hC3, 0);
    send(tlnp_pkg::MODE_SEARCH, 1'b1, hot_node, 8'hC3, 0);
    send(tlnp_pkg::MODE_FREE, 1'b1, hot_node, 8'h00, 0);

    // Alternate filling and draining phases; one phase always runs without gaps.
    for (int p = 0; p < PHASES; p++) begin
      no_gaps = (p == 3) || ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) random_cmd(p % 2 == 0, no_gaps);
    end

    drain_pending();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_typed_list_node_pool_unit passed");
    else
      $display("tb_typed_list_node_pool_unit failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tlnp_pkg.sv
sv/tlnp_ram.sv
sv/tlnp_store.sv
sv/tlnp_ctrl.sv
sv/typed_list_node_pool_unit.sv
dv/tb_typed_list_node_pool_unit.sv
